>>> rtl/rrts_pkg.sv
// Shared types and constants for the round-robin task scheduler.
package rrts_pkg;

  // Fixed field widths of the command and result words.
  localparam int unsigned ACTION_W = 4;
  localparam int unsigned TASK_W   = 3;
  localparam int unsigned AMOUNT_W = 16;
  localparam int unsigned STATUS_W = 8;
  localparam int unsigned TOTAL_W  = 4;
  localparam int unsigned PARAM_W  = 4;

  // Status byte bits; a status of zero means suspended.
  localparam logic [STATUS_W-1:0] STAT_READY     = 8'h01;
  localparam logic [STATUS_W-1:0] STAT_WAIT_TIME = 8'h02;
  localparam logic [STATUS_W-1:0] STAT_WAIT_SEMA = 8'h04;
  localparam logic [STATUS_W-1:0] STAT_TIMEOUT   = 8'h08;
  localparam int unsigned         PARAM_SHIFT    = 4;

  // Action codes of a command word.
  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK      = 4'd0,
    ACT_YIELD     = 4'd1,
    ACT_DELAY     = 4'd2,
    ACT_WAIT_SEMA = 4'd3,
    ACT_SEND_SEMA = 4'd4,
    ACT_SET_OWN   = 4'd5,
    ACT_SET_TASK  = 4'd6,
    ACT_CREATE    = 4'd7,
    ACT_START     = 4'd8
  } act_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SEND,
    S_TICK,
    S_SEARCH,
    S_OUT_RD,
    S_OUT
  } state_e;

  // Command word.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [TASK_W-1:0]   task_index;
    logic [AMOUNT_W-1:0] tick_amount;
    logic [STATUS_W-1:0] value;
  } in_t;

  // Result word.
  typedef struct packed {
    logic [TASK_W-1:0]   running_task;
    logic [STATUS_W-1:0] running_status;
    logic                wait_timed_out;
    logic [PARAM_W-1:0]  wait_value;
    logic [TOTAL_W-1:0]  tasks_in_use;
  } out_t;

endpackage

>>> rtl/rrts_mem.sv
// Per-task table: one write port, one registered read port, optional reset-to-zero.
module rrts_mem
  import rrts_pkg::*;
#(
  parameter int unsigned DEPTH     = 8,
  parameter int unsigned WIDTH     = 8,
  parameter bit          CLEAR_RST = 1'b1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q;

  // Storage array and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
  end

  if (CLEAR_RST) begin : g_clear
    logic [DEPTH-1:0] vld_q;
    logic             rvld_q;

    // Entries never written since reset read as zero.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q  <= '0;
        rvld_q <= 1'b0;
      end else begin
        if (we_i) begin
          vld_q[waddr_i] <= 1'b1;
        end
        rvld_q <= vld_q[raddr_i];
      end
    end

    assign rdata_o = rvld_q ? rd_q : '0;
  end else begin : g_plain
    assign rdata_o = rd_q;
  end

endmodule

>>> rtl/round_robin_task_scheduler_unit.sv
// Round-robin task scheduler: command sequencer over the status and wait-counter tables.
// An accepted word passes through S_EXEC, S_OUT_RD and S_OUT before the result strobe;
// a send adds S_SEND, a tick with tasks created adds the counter walk in S_TICK, and a
// search adds S_SEARCH; the walk and the search step through the single read port of
// each table. One word at a time; busy drops as the strobe rises. Reset clears the
// status table, task count and current task.
module round_robin_task_scheduler_unit
  import rrts_pkg::*;
#(
  parameter int unsigned MAX_TASKS  = 8,
  parameter int unsigned TICK_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  item_i,
  output logic done_o,
  output out_t result_o
);

  localparam int unsigned CW = $clog2(MAX_TASKS);
  localparam int unsigned TW = $clog2(MAX_TASKS + 1);
  localparam int unsigned NW = TW + 1;

  state_e          state_q, state_d;
  in_t             item_q, item_d;
  logic [CW-1:0]   cur_q, cur_d;
  logic [TW-1:0]   total_q, total_d;
  logic [TW-1:0]   ti_q, ti_d;
  logic            p_vld_q, p_vld_d;
  logic [CW-1:0]   p_idx_q, p_idx_d;
  logic [CW-1:0]   iss_q, iss_d;
  logic            chk_vld_q, chk_vld_d;
  logic [CW-1:0]   chk_task_q, chk_task_d;
  logic [TW-1:0]   ex_q, ex_d;
  out_t            res_q, res_d;
  logic            done_q, done_d;

  logic                  st_we, ct_we;
  logic [CW-1:0]         st_waddr, ct_waddr, raddr;
  logic [STATUS_W-1:0]   st_wdata, st_rdata;
  logic [TICK_WIDTH-1:0] ct_wdata, ct_rdata;

  // Status table, cleared by reset.
  rrts_mem #(
    .DEPTH     (MAX_TASKS),
    .WIDTH     (STATUS_W),
    .CLEAR_RST (1'b1)
  ) u_status (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (raddr),
    .rdata_o (st_rdata)
  );

  // Wait counter table, undefined until written.
  rrts_mem #(
    .DEPTH     (MAX_TASKS),
    .WIDTH     (TICK_WIDTH),
    .CLEAR_RST (1'b0)
  ) u_count (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (ct_we),
    .waddr_i (ct_waddr),
    .wdata_i (ct_wdata),
    .raddr_i (raddr),
    .rdata_o (ct_rdata)
  );

  // Next round-robin candidate: wraps to task 1 past the last created task.
  function automatic logic [CW-1:0] nxt_task(input logic [CW-1:0] x,
                                              input logic [TW-1:0] tot);
    logic [NW-1:0] p;
    p = NW'(x) + NW'(1);
    if (p >= NW'(tot)) begin
      return CW'(1);
    end
    return CW'(p);
  endfunction

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cur_q     <= '0;
      total_q   <= '0;
      ti_q      <= '0;
      p_vld_q   <= 1'b0;
      chk_vld_q <= 1'b0;
      ex_q      <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      total_q   <= total_d;
      ti_q      <= ti_d;
      p_vld_q   <= p_vld_d;
      chk_vld_q <= chk_vld_d;
      ex_q      <= ex_d;
      done_q    <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    p_idx_q    <= p_idx_d;
    iss_q      <= iss_d;
    chk_task_q <= chk_task_d;
    res_q      <= res_d;
  end

  // Sequencer: next state, table accesses and result.
  always_comb begin
    logic [CW-1:0]         tgt;
    logic                  tgt_ok;
    logic [TICK_WIDTH-1:0] ticks;
    logic [TICK_WIDTH-1:0] ct_dec;
    logic [CW-1:0]         nx;
    logic                  go_search;

    tgt    = CW'(item_q.task_index);
    tgt_ok = 32'(item_q.task_index) < 32'(MAX_TASKS);
    ticks  = TICK_WIDTH'(item_q.tick_amount);
    ct_dec = (ct_rdata != '0) ? ct_rdata - TICK_WIDTH'(1) : ct_rdata;
    nx     = nxt_task(iss_q, total_q);
    go_search = 1'b0;

    state_d    = state_q;
    item_d     = item_q;
    cur_d      = cur_q;
    total_d    = total_q;
    ti_d       = ti_q;
    p_vld_d    = 1'b0;
    p_idx_d    = p_idx_q;
    iss_d      = iss_q;
    chk_vld_d  = chk_vld_q;
    chk_task_d = chk_task_q;
    ex_d       = ex_q;
    res_d      = res_q;
    done_d     = 1'b0;

    st_we    = 1'b0;
    st_waddr = cur_q;
    st_wdata = '0;
    ct_we    = 1'b0;
    ct_waddr = cur_q;
    ct_wdata = ticks;
    raddr    = cur_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          item_d  = item_i;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d = S_OUT_RD;
        case (item_q.action)
          ACT_TICK: begin
            ti_d = '0;
            if (total_q == '0) begin
              go_search = 1'b1;
            end else begin
              state_d = S_TICK;
            end
          end
          ACT_YIELD: begin
            go_search = 1'b1;
          end
          ACT_DELAY: begin
            ct_we     = 1'b1;
            st_we     = 1'b1;
            st_wdata  = STAT_WAIT_TIME;
            go_search = 1'b1;
          end
          ACT_WAIT_SEMA: begin
            if (total_q != '0) begin
              st_we     = 1'b1;
              st_wdata  = STAT_WAIT_SEMA | ((ticks != '0) ? STAT_WAIT_TIME : '0);
              ct_we     = (ticks != '0);
              go_search = 1'b1;
            end
          end
          ACT_SEND_SEMA: begin
            if (tgt_ok) begin
              raddr   = tgt;
              state_d = S_SEND;
            end
          end
          ACT_SET_OWN: begin
            if (32'(cur_q) < 32'(total_q)) begin
              st_we     = 1'b1;
              st_wdata  = item_q.value;
              go_search = 1'b1;
            end
          end
          ACT_SET_TASK: begin
            if (32'(item_q.task_index) < 32'(total_q)) begin
              st_we     = 1'b1;
              st_waddr  = tgt;
              st_wdata  = item_q.value;
              go_search = 1'b1;
            end
          end
          ACT_CREATE: begin
            if (tgt_ok) begin
              st_we    = 1'b1;
              st_waddr = tgt;
              st_wdata = item_q.value;
              ct_we    = 1'b1;
              ct_waddr = tgt;
              ct_wdata = '0;
              if (32'(total_q) < 32'(item_q.task_index) + 32'd1) begin
                total_d = TW'(32'(item_q.task_index) + 32'd1);
              end
            end
          end
          ACT_START: begin
            cur_d = CW'(1);
          end
          default: begin
          end
        endcase
      end

      // Send completes only for a task that waits on a semaphore.
      S_SEND: begin
        if ((st_rdata & STAT_WAIT_SEMA) != '0) begin
          st_we    = 1'b1;
          st_waddr = tgt;
          st_wdata = (STATUS_W'(item_q.value[PARAM_W-1:0]) << PARAM_SHIFT) | STAT_READY;
        end
        state_d = S_OUT_RD;
      end

      // Counter walk: read one task per cycle, update the one read before.
      S_TICK: begin
        if (ti_q < total_q) begin
          raddr   = CW'(ti_q);
          p_vld_d = 1'b1;
          p_idx_d = CW'(ti_q);
          ti_d    = ti_q + TW'(1);
        end
        if (p_vld_q) begin
          if ((st_rdata & STAT_WAIT_TIME) != '0) begin
            ct_we    = 1'b1;
            ct_waddr = p_idx_q;
            ct_wdata = ct_dec;
            if (ct_dec == '0) begin
              st_we    = 1'b1;
              st_waddr = p_idx_q;
              st_wdata = STAT_TIMEOUT | STAT_READY;
            end
          end
          if (32'(p_idx_q) + 32'd1 == 32'(total_q)) begin
            go_search = 1'b1;
          end
        end
      end

      // Ready search: one candidate read per cycle, checked in the cycle after its read.
      S_SEARCH: begin
        if (chk_vld_q && ((st_rdata & STAT_READY) != '0)) begin
          cur_d   = chk_task_q;
          state_d = S_OUT_RD;
        end else if (chk_vld_q && (ex_q >= total_q)) begin
          cur_d   = '0;
          state_d = S_OUT_RD;
        end else begin
          if (chk_vld_q) begin
            ex_d = ex_q + TW'(1);
          end
          raddr      = nx;
          chk_task_d = nx;
          chk_vld_d  = 1'b1;
          iss_d      = nx;
        end
      end

      S_OUT_RD: begin
        raddr   = cur_q;
        state_d = S_OUT;
      end

      // Build the result word from the running task's status.
      S_OUT: begin
        res_d.running_task   = TASK_W'(cur_q);
        res_d.running_status = st_rdata & ~STAT_TIMEOUT;
        res_d.wait_timed_out = (st_rdata & STAT_TIMEOUT) != '0;
        res_d.wait_value     = st_rdata[PARAM_SHIFT +: PARAM_W];
        res_d.tasks_in_use   = TOTAL_W'(total_q);
        done_d               = 1'b1;
        state_d              = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (go_search) begin
      iss_d     = cur_q;
      chk_vld_d = 1'b0;
      ex_d      = '0;
      state_d   = S_SEARCH;
    end
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the round-robin task scheduler unit.
`timescale 1ns / 1ps

module tb_top
  import rrts_pkg::*;
();

  localparam int unsigned NUM_TASKS   = 8;
  localparam int unsigned N_RANDOM    = 1500;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_EVERY = 250;
  localparam int unsigned SETTLE_CYC  = 40;

  // Action codes the block ignores.
  localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 4'd9;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 4'd15;

  // Tracks the scheduler state and checks each result word against it.
  class sched_scoreboard;
    logic [STATUS_W-1:0] status_tbl[NUM_TASKS];
    int unsigned         wait_cnt[NUM_TASKS];
    bit                  cnt_known[NUM_TASKS];
    int unsigned         cur_task;
    int unsigned         total_tasks;
    out_t                run_reports[$];
    int unsigned         errors;
    int unsigned         n_words;
    int unsigned         n_ticks;
    int unsigned         n_timeouts;
    int unsigned         n_idle;

    function new();
      for (int unsigned i = 0; i < NUM_TASKS; i++) begin
        status_tbl[i] = '0;
        wait_cnt[i]   = 0;
        cnt_known[i]  = 1'b0;
      end
      cur_task    = 0;
      total_tasks = 0;
      errors      = 0;
      n_words     = 0;
      n_ticks     = 0;
      n_timeouts  = 0;
      n_idle      = 0;
    endfunction

    // Round-robin search over tasks 1..count-1; the idle task wins if none is ready.
    function void pick_next_ready();
      int unsigned tries;
      int unsigned nxt;
      tries = 0;
      while (1) begin
        nxt = cur_task + 1;
        if (nxt >= total_tasks || nxt >= NUM_TASKS) begin
          nxt = 1;
        end
        cur_task = nxt;
        if ((status_tbl[cur_task] & STAT_READY) != '0) begin
          break;
        end
        tries++;
        if (tries > total_tasks) begin
          cur_task = 0;
          break;
        end
      end
    endfunction

    // One tick: every time-waiting task counts down and wakes at zero.
    function void count_down_waits();
      int unsigned i;
      for (i = 0; i < total_tasks && i < NUM_TASKS; i++) begin
        if ((status_tbl[i] & STAT_WAIT_TIME) != '0) begin
          if (wait_cnt[i] != 0) begin
            wait_cnt[i]--;
          end
          if (wait_cnt[i] == 0) begin
            status_tbl[i] = STAT_TIMEOUT | STAT_READY;
          end
        end
      end
      pick_next_ready();
    endfunction

    // Applies an accepted command word and queues the result it must produce.
    function void note_word(in_t w);
      int unsigned         tgt;
      logic [STATUS_W-1:0] st;
      out_t                rep;
      tgt = w.task_index;
      n_words++;
      case (w.action)
        ACT_TICK: begin
          n_ticks++;
          count_down_waits();
        end
        ACT_YIELD: begin
          pick_next_ready();
        end
        ACT_DELAY: begin
          wait_cnt[cur_task]   = w.tick_amount;
          cnt_known[cur_task]  = 1'b1;
          status_tbl[cur_task] = STAT_WAIT_TIME;
          pick_next_ready();
        end
        ACT_WAIT_SEMA: begin
          if (total_tasks != 0) begin
            status_tbl[cur_task] = STAT_WAIT_SEMA;
            if (w.tick_amount != '0) begin
              wait_cnt[cur_task]   = w.tick_amount;
              cnt_known[cur_task]  = 1'b1;
              status_tbl[cur_task] = status_tbl[cur_task] | STAT_WAIT_TIME;
            end
            pick_next_ready();
          end
        end
        ACT_SEND_SEMA: begin
          if ((status_tbl[tgt] & STAT_WAIT_SEMA) != '0) begin
            status_tbl[tgt] = {w.value[PARAM_W-1:0], 4'b0000} | STAT_READY;
          end
        end
        ACT_SET_OWN: begin
          if (cur_task < total_tasks) begin
            status_tbl[cur_task] = w.value;
            pick_next_ready();
          end
        end
        ACT_SET_TASK: begin
          if (tgt < total_tasks) begin
            status_tbl[tgt] = w.value;
            pick_next_ready();
          end
        end
        ACT_CREATE: begin
          status_tbl[tgt] = w.value;
          wait_cnt[tgt]   = 0;
          cnt_known[tgt]  = 1'b1;
          if (total_tasks < tgt + 1) begin
            total_tasks = tgt + 1;
          end
        end
        ACT_START: begin
          cur_task = 1;
        end
        default: begin
        end
      endcase

      st = status_tbl[cur_task];
      rep.running_task   = TASK_W'(cur_task);
      rep.running_status = st & ~STAT_TIMEOUT;
      rep.wait_timed_out = (st & STAT_TIMEOUT) != '0;
      rep.wait_value     = st[STATUS_W-1:PARAM_SHIFT];
      rep.tasks_in_use   = TOTAL_W'(total_tasks);
      run_reports.push_back(rep);
    endfunction

    function void compare_field(string fname, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", fname, want, got);
        errors++;
      end
    endfunction

    // Checks one result word against the oldest outstanding expectation.
    function void check_word(out_t r);
      out_t want;
      if (run_reports.size() == 0) begin
        $error("result strobe with no command outstanding");
        errors++;
        return;
      end
      want = run_reports.pop_front();
      if (want.wait_timed_out) begin
        n_timeouts++;
      end
      if (want.running_task == '0) begin
        n_idle++;
      end
      compare_field("running_task", want.running_task, r.running_task);
      compare_field("running_status", want.running_status, r.running_status);
      compare_field("wait_timed_out", want.wait_timed_out, r.wait_timed_out);
      compare_field("wait_value", want.wait_value, r.wait_value);
      compare_field("tasks_in_use", want.tasks_in_use, r.tasks_in_use);
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            start;
  logic            busy;
  in_t             item_i;
  logic            done_o;
  out_t            result_o;
  sched_scoreboard sb;
  int unsigned     cycle_count = 0;

  round_robin_task_scheduler_unit i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // 20 ns clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sample accepted commands and result strobes at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && sb != null) begin
      if (start && !busy) begin
        sb.note_word(item_i);
      end
      if (done_o) begin
        sb.check_word(result_o);
      end
    end
  end

  function automatic in_t cmd(logic [ACTION_W-1:0] act, int unsigned idx,
                              int unsigned amt, int unsigned val);
    in_t w;
    w.action      = act;
    w.task_index  = TASK_W'(idx);
    w.tick_amount = AMOUNT_W'(amt);
    w.value       = STATUS_W'(val);
    return w;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int unsigned pick_gap(bit burst);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst || r < 40) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Random command, biased toward sequences that exercise waits and wake-ups.
  function automatic in_t make_word();
    in_t         w;
    int unsigned r;
    int unsigned tgt;
    int unsigned base;
    int unsigned k;
    bit          found;
    w.task_index = TASK_W'($urandom_range(0, NUM_TASKS - 1));
    w.value      = STATUS_W'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 70) begin
      w.tick_amount = AMOUNT_W'($urandom_range(0, 6));
    end else if (r < 90) begin
      w.tick_amount = AMOUNT_W'($urandom_range(0, 40));
    end else begin
      w.tick_amount = AMOUNT_W'($urandom_range(0, 65535));
    end
    r = $urandom_range(0, 99);
    if (r < 28) begin
      w.action = ACT_TICK;
    end else if (r < 36) begin
      w.action = ACT_YIELD;
    end else if (r < 46) begin
      w.action = ACT_DELAY;
    end else if (r < 56) begin
      w.action = ACT_WAIT_SEMA;
    end else if (r < 68) begin
      w.action = ACT_SEND_SEMA;
    end else if (r < 74) begin
      w.action = ACT_SET_OWN;
    end else if (r < 80) begin
      w.action = ACT_SET_TASK;
    end else if (r < 88) begin
      w.action = ACT_CREATE;
    end else if (r < 92) begin
      w.action = ACT_START;
    end else begin
      w.action = ACTION_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
    end

    // Sends usually go to a task that is actually blocked on the semaphore.
    if (w.action == ACT_SEND_SEMA && $urandom_range(0, 99) < 70) begin
      base  = $urandom_range(0, NUM_TASKS - 1);
      found = 1'b0;
      for (k = 0; k < NUM_TASKS; k++) begin
        if (!found && (sb.status_tbl[(base + k) % NUM_TASKS] & STAT_WAIT_SEMA) != '0) begin
          w.task_index = TASK_W'((base + k) % NUM_TASKS);
          found        = 1'b1;
        end
      end
    end

    // A time wait must never be set on a task whose counter was never loaded.
    tgt = (w.action == ACT_SET_OWN) ? sb.cur_task : w.task_index;
    if ((w.action == ACT_SET_OWN || w.action == ACT_SET_TASK) && !sb.cnt_known[tgt]) begin
      w.value = w.value & ~STAT_WAIT_TIME;
    end
    return w;
  endfunction

  // Presents one word after an idle gap, if any, and holds it until the block takes it.
  task automatic drive_word(input in_t w, input int unsigned gap);
    if (gap != 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // Let the scoreboard take the accepted word before the next one is built.
    #1;
  endtask

  // Stops sending until every outstanding result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.run_reports.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    in_t         directed[$];
    int unsigned counted;
    bit          burst;
    in_t         w;

    sb          = new();
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: empty scheduler corners, then a small task set through
    // delays, timeouts and semaphore hand-offs.
    directed.push_back(cmd(ACT_TICK, 0, 0, 0));
    directed.push_back(cmd(ACT_YIELD, 0, 0, 0));
    directed.push_back(cmd(ACT_WAIT_SEMA, 0, 5, 0));      // no tasks yet
    directed.push_back(cmd(ACT_DELAY, 0, 0, 0));          // no tasks, still written
    directed.push_back(cmd(ACT_SET_OWN, 0, 0, 255));      // current beyond count
    directed.push_back(cmd(ACT_SET_TASK, 7, 0, 255));     // target beyond count
    directed.push_back(cmd(ACT_SEND_SEMA, 7, 0, 15));     // target not waiting
    directed.push_back(cmd(ACT_UNUSED_LO, 7, 65535, 255));
    directed.push_back(cmd(ACT_UNUSED_HI, 0, 0, 0));
    directed.push_back(cmd(ACT_START, 0, 0, 0));
    directed.push_back(cmd(ACT_CREATE, 0, 0, 1));
    directed.push_back(cmd(ACT_YIELD, 0, 0, 0));          // fewer than two tasks
    directed.push_back(cmd(ACT_CREATE, 3, 0, 1));
    directed.push_back(cmd(ACT_CREATE, 1, 0, 1));
    directed.push_back(cmd(ACT_CREATE, 2, 0, 0));
    directed.push_back(cmd(ACT_TICK, 0, 0, 0));
    directed.push_back(cmd(ACT_DELAY, 0, 0, 0));          // zero-length delay
    directed.push_back(cmd(ACT_TICK, 0, 0, 0));
    directed.push_back(cmd(ACT_WAIT_SEMA, 0, 0, 0));      // wait without timeout
    directed.push_back(cmd(ACT_SEND_SEMA, 1, 0, 15));
    directed.push_back(cmd(ACT_WAIT_SEMA, 0, 2, 0));      // wait with timeout
    directed.push_back(cmd(ACT_TICK, 0, 0, 0));
    directed.push_back(cmd(ACT_TICK, 0, 0, 0));
    directed.push_back(cmd(ACT_SET_TASK, 2, 0, 1));
    directed.push_back(cmd(ACT_SET_OWN, 0, 0, 0));
    foreach (directed[i]) begin
      drive_word(directed[i], 0);
    end
    drain_results();

    // Random part, with runs of back-to-back words and periodic drains.
    counted = 0;
    while (counted < N_RANDOM) begin
      burst = ((counted / 100) % 3) == 0;
      w     = make_word();
      drive_word(w, pick_gap(burst));
      if (w.action < ACT_UNUSED_LO) begin
        counted++;
        if (counted % DRAIN_EVERY == 0) begin
          drain_results();
        end
      end
    end

    drain_results();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (sb.run_reports.size() != 0) begin
      $error("%0d results never arrived", sb.run_reports.size());
      sb.errors++;
    end

    $display("Ran %0d commands, %0d of them ticks, over growing task sets.",
             sb.n_words, sb.n_ticks);
    $display("Results showed %0d timed-out wake-ups and %0d idle-task picks.",
             sb.n_timeouts, sb.n_idle);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
